// File: hdl/decimal_text_to_fixed_parser_defines.svh
// assertion macros for the decimal text to fixed-point parser
`ifndef DECIMAL_TEXT_TO_FIXED_PARSER_DEFINES_SVH
`define DECIMAL_TEXT_TO_FIXED_PARSER_DEFINES_SVH

// same-cycle implication on clk, disabled in reset
`define DTFP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, disabled in reset
`define DTFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/dtfp_pkg.sv
// shared types and constants of the decimal text to fixed-point parser
package dtfp_pkg;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;

	localparam logic [5:0] NARROW_MAX_DIGITS = 6'd18;
	localparam logic [5:0] WIDE_MAX_DIGITS   = 6'd38;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	localparam logic REG_WIDE_MODE = 1'b0;
	localparam logic WIDE_MODE_RESET = 1'b1;

	typedef struct packed {
		logic [5:0] digits;
		logic [5:0] scale;
		logic       after_point;
		logic       skipping_zeros;
		logic       negative;
		logic       failed;
		logic       at_first;
	} dtfp_state_t;

	localparam dtfp_state_t STATE_RESET = '{
		digits: 6'd0,
		scale: 6'd0,
		after_point: 1'b0,
		skipping_zeros: 1'b1,
		negative: 1'b0,
		failed: 1'b0,
		at_first: 1'b1
	};

	typedef struct packed {
		logic [63:0] value_low;
		logic [63:0] value_high;
		logic [5:0]  digit_count;
		logic [5:0]  frac_digits;
		logic        status;
	} dtfp_result_t;

endpackage

// File: hdl/dtfp_apb_regs.sv
// apb configuration register holding the decimal width mode
module dtfp_apb_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic        wide_mode
);
	import dtfp_pkg::*;

	logic wide_mode_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_mode_q <= WIDE_MODE_RESET;
		end else if (wr_en && (paddr[2] == REG_WIDE_MODE)) begin
			wide_mode_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		unique case (paddr[2])
			REG_WIDE_MODE: prdata = {31'd0, wide_mode_q};
			default: prdata = 32'd0;
		endcase
	end

	assign wide_mode = wide_mode_q;

endmodule

// File: hdl/dtfp_char_step.sv
// per-character next-state logic and end-of-string result formatting
module dtfp_char_step #(
	parameter int ACC_WIDTH = 128
) (
	input  logic                   wide_mode,
	input  logic [7:0]             char_code,
	input  logic                   char_valid,
	input  logic                   is_last,
	input  logic [ACC_WIDTH-1:0]   acc_cur,
	input  dtfp_pkg::dtfp_state_t  st_cur,
	output logic [ACC_WIDTH-1:0]   acc_next,
	output dtfp_pkg::dtfp_state_t  st_next,
	output dtfp_pkg::dtfp_result_t result
);
	import dtfp_pkg::*;

	dtfp_state_t          st_n;
	logic                 take;
	logic [5:0]           maxd;
	logic [ACC_WIDTH-1:0] dext;
	logic [ACC_WIDTH-1:0] sum;
	logic [ACC_WIDTH-1:0] acc_n;
	logic [63:0]          low;
	logic                 fill;
	logic [127:0]         narrow_ext;
	logic [127+ACC_WIDTH:0] wide_ext;
	logic [127:0]         value;
	logic                 err;

	assign maxd = wide_mode ? WIDE_MAX_DIGITS : NARROW_MAX_DIGITS;

	always_comb begin
		st_n = st_cur;
		take = 1'b0;
		if (char_valid) begin
			st_n.at_first = 1'b0;
			if (!st_cur.failed) begin
				if (st_cur.at_first && (char_code == CH_MINUS || char_code == CH_PLUS)) begin
					st_n.negative = (char_code == CH_MINUS);
				end else if (char_code == CH_POINT) begin
					st_n.after_point = 1'b1;
					st_n.skipping_zeros = 1'b0;
				end else if (char_code >= CH_0 && char_code <= CH_9 &&
					!(char_code == CH_0 && st_cur.skipping_zeros)) begin
					st_n.skipping_zeros = 1'b0;
					if (({1'b0, st_cur.digits} + 7'd1) > {1'b0, maxd}) begin
						if (!st_cur.after_point) begin
							st_n.failed = 1'b1;
						end
					end else begin
						st_n.digits = st_cur.digits + 6'd1;
						if (st_cur.after_point) begin
							st_n.scale = st_cur.scale + 6'd1;
						end
						take = 1'b1;
					end
				end
			end
		end
	end

	// accumulator is kept signed: acc*10 - digit once the sign is negative
	assign dext = {{(ACC_WIDTH-4){1'b0}}, char_code[3:0]};
	assign sum = (acc_cur << 3) + (acc_cur << 1) + (st_cur.negative ? ~dext : dext)
		+ {{(ACC_WIDTH-1){1'b0}}, st_cur.negative};
	assign low = sum[63:0];
	assign fill = st_cur.negative && (low != 64'd0);
	assign narrow_ext = {{64{fill}}, low};

	always_comb begin
		acc_n = acc_cur;
		if (take) begin
			acc_n = wide_mode ? sum : narrow_ext[ACC_WIDTH-1:0];
		end
	end

	assign wide_ext = {{128{acc_n[ACC_WIDTH-1]}}, acc_n};
	assign value = wide_mode ? wide_ext[127:0] : {{64{acc_n[63]}}, acc_n[63:0]};
	assign err = st_n.failed || st_n.at_first;

	always_comb begin
		if (err) begin
			result.value_low   = 64'd0;
			result.value_high  = 64'd0;
			result.digit_count = 6'd0;
			result.frac_digits = 6'd0;
			result.status      = STATUS_ERR;
		end else begin
			result.value_low   = value[63:0];
			result.value_high  = value[127:64];
			result.digit_count = st_n.digits;
			result.frac_digits = st_n.scale;
			result.status      = STATUS_OK;
		end
	end

	assign acc_next = is_last ? '0 : acc_n;
	assign st_next  = is_last ? STATE_RESET : st_n;

endmodule

// File: hdl/decimal_text_to_fixed_parser.sv
// a character beat is registered in s1; a string's last beat loads the result register
// throughput: one character per cycle unless stalled, via a times-ten-and-add accumulator
// the input stalls only while a last beat in s1 waits on a full, stalled output register
// reset: asynchronous, clears pipeline valids and per-string state, wide mode set to one
// no clearing pass after reset
module decimal_text_to_fixed_parser #(
	parameter int ACC_WIDTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         char_code,
	input  logic               char_valid,
	input  logic               is_last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [63:0]        value_low,
	output logic signed [63:0] value_high,
	output logic [5:0]         digit_count,
	output logic [5:0]         frac_digits,
	output logic               status
);
	import dtfp_pkg::*;

	`include "decimal_text_to_fixed_parser_defines.svh"

	logic                 wide_mode;
	logic                 valid_s1;
	logic [7:0]           char_code_s1;
	logic                 char_valid_s1;
	logic                 is_last_s1;
	logic [ACC_WIDTH-1:0] acc_q;
	logic [ACC_WIDTH-1:0] acc_next;
	dtfp_state_t          st_q;
	dtfp_state_t          st_next;
	dtfp_result_t         result;
	dtfp_result_t         result_q;
	logic                 out_valid_q;
	logic                 out_free;
	logic                 go_s1;

	dtfp_apb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.wide_mode (wide_mode)
	);

	dtfp_char_step #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_step (
		.wide_mode  (wide_mode),
		.char_code  (char_code_s1),
		.char_valid (char_valid_s1),
		.is_last    (is_last_s1),
		.acc_cur    (acc_q),
		.st_cur     (st_q),
		.acc_next   (acc_next),
		.st_next    (st_next),
		.result     (result)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && is_last_s1 && !out_free;
	assign go_s1 = valid_s1 && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_code_s1  <= char_code;
			char_valid_s1 <= char_valid;
			is_last_s1    <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			st_q  <= STATE_RESET;
		end else if (go_s1) begin
			acc_q <= acc_next;
			st_q  <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && is_last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && is_last_s1) begin
			result_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign value_low   = result_q.value_low;
	assign value_high  = result_q.value_high;
	assign digit_count = result_q.digit_count;
	assign frac_digits = result_q.frac_digits;
	assign status      = result_q.status;

	`DTFP_ASSERT_NOW(a_err_beat_zero, out_valid && status == STATUS_ERR,
		value_low == 64'd0 && value_high == 64'sd0 && digit_count == 6'd0 && frac_digits == 6'd0,
		"error beat carries nonzero fields")
	`DTFP_ASSERT_NOW(a_scale_le_digits, out_valid, frac_digits <= digit_count,
		"frac digits exceed digit count")
	`DTFP_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall,
		"input stalled without a blocked result")
	`DTFP_ASSERT_NEXT(a_last_clears, go_s1 && is_last_s1, st_q == STATE_RESET && acc_q == '0,
		"string state not cleared after last beat")

endmodule

// File: bench/decimal_text_to_fixed_parser_checker.sv
`timescale 1ns / 1ps
// checker that predicts and compares every parsed number of the decimal text parser
module decimal_text_to_fixed_parser_checker #(
	parameter int ACC_WIDTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [7:0]         char_code,
	input  logic               char_valid,
	input  logic               is_last,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [63:0]        value_low,
	input  logic signed [63:0] value_high,
	input  logic [5:0]         digit_count,
	input  logic [5:0]         frac_digits,
	input  logic               status,
	output int                 errors,
	output int                 pending
);
	import dtfp_pkg::*;

	localparam logic [127:0] ACC_MASK = (ACC_WIDTH >= 128) ? {128{1'b1}} :
		((128'd1 << ACC_WIDTH) - 128'd1);
	localparam logic [2:0] WIDE_MODE_ADDR = 3'(4 * int'(REG_WIDE_MODE));

	dtfp_state_t scan;
	logic [127:0] acc;
	logic wide;
	dtfp_result_t parsed_numbers[$];

	function automatic void absorb_char(input logic [7:0] c);
		logic first;
		logic [5:0] max_digits;
		first = scan.at_first;
		scan.at_first = 1'b0;
		max_digits = wide ? WIDE_MAX_DIGITS : NARROW_MAX_DIGITS;
		if (first && (c == CH_MINUS || c == CH_PLUS)) begin
			scan.negative = (c == CH_MINUS);
		end else if (c == CH_POINT) begin
			scan.after_point = 1'b1;
			scan.skipping_zeros = 1'b0;
		end else if (c >= CH_0 && c <= CH_9 && !(c == CH_0 && scan.skipping_zeros)) begin
			scan.skipping_zeros = 1'b0;
			if (scan.digits >= max_digits) begin
				// too many digits: fraction digits drop, integer digits fail the string
				if (!scan.after_point)
					scan.failed = 1'b1;
			end else begin
				scan.digits = scan.digits + 6'd1;
				if (scan.after_point)
					scan.scale = scan.scale + 6'd1;
				acc = acc * 128'd10 + 128'(c - CH_0);
				acc = wide ? (acc & ACC_MASK) : {64'd0, acc[63:0]};
			end
		end
	endfunction

	function automatic dtfp_result_t close_number();
		dtfp_result_t r;
		logic [127:0] v;
		r = '0;
		r.status = STATUS_ERR;
		if (!scan.failed && !scan.at_first) begin
			v = scan.negative ? (~acc + 128'd1) : acc;
			if (!wide || ACC_WIDTH <= 64)
				v[127:64] = {64{v[63]}};
			else
				v = v[ACC_WIDTH-1] ? (v | ~ACC_MASK) : (v & ACC_MASK);
			r.value_low = v[63:0];
			r.value_high = v[127:64];
			r.digit_count = scan.digits;
			r.frac_digits = scan.scale;
			r.status = STATUS_OK;
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %h got %h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dtfp_result_t want;
		if (!arst_n) begin
			scan = STATE_RESET;
			acc = '0;
			wide = WIDE_MODE_RESET;
			parsed_numbers.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (parsed_numbers.size() == 0) begin
					$display("%0t ns: number expected none got low %h high %h digits %0d frac %0d status %b",
						$time, value_low, value_high, digit_count, frac_digits, status);
					errors++;
				end else begin
					want = parsed_numbers.pop_front();
					check_field("value_low", want.value_low, value_low);
					check_field("value_high", want.value_high, value_high);
					check_field("digit_count", 64'(want.digit_count), 64'(digit_count));
					check_field("frac_digits", 64'(want.frac_digits), 64'(frac_digits));
					check_field("status", 64'(want.status), 64'(status));
				end
			end
			if (in_valid && !in_stall) begin
				if (char_valid && !scan.failed)
					absorb_char(char_code);
				else if (char_valid)
					scan.at_first = 1'b0;
				if (is_last) begin
					parsed_numbers.push_back(close_number());
					scan = STATE_RESET;
					acc = '0;
				end
			end
			if (psel && penable && pwrite && pready && paddr == WIDE_MODE_ADDR)
				wide = pwdata[0];
			pending <= parsed_numbers.size();
		end
	end

endmodule

// File: bench/decimal_text_to_fixed_parser_tb.sv
`timescale 1ns / 1ps
// stimulus, clock, reset and verdict for the decimal text to fixed-point parser
module decimal_text_to_fixed_parser_tb;
	import dtfp_pkg::*;

	localparam logic [7:0] CH_EXP_LOW = 8'h65;
	localparam logic [7:0] CH_EXP_UP  = 8'h45;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_CHARS = 95;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         char_code = '0;
	logic               char_valid = 1'b0;
	logic               is_last = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [63:0]        value_low;
	logic signed [63:0] value_high;
	logic [5:0]         digit_count;
	logic [5:0]         frac_digits;
	logic               status;
	int                 errors;
	int                 pending;

	logic [7:0] text[$];
	bit calm = 1'b0;
	bit hold_out = 1'b0;
	int chars_sent = 0;

	decimal_text_to_fixed_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.char_valid(char_valid),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value_low(value_low),
		.value_high(value_high),
		.digit_count(digit_count),
		.frac_digits(frac_digits),
		.status(status)
	);

	decimal_text_to_fixed_parser_checker number_check (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.char_valid(char_valid),
		.is_last(is_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value_low(value_low),
		.value_high(value_high),
		.digit_count(digit_count),
		.frac_digits(frac_digits),
		.status(status),
		.errors(errors),
		.pending(pending)
	);

	always #5 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_beat(input logic [7:0] code, input logic cv, input logic last);
		int gap;
		gap = calm ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= code;
		char_valid <= cv;
		is_last <= last;
		do @(posedge clk); while (in_stall);
		if (cv || last)
			chars_sent++;
	endtask

	task automatic send_text();
		bit tail_empty;
		tail_empty = (text.size() == 0) || ($urandom_range(0, 9) == 0);
		for (int i = 0; i < text.size(); i++) begin
			if (!calm && $urandom_range(0, 19) == 0)
				send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_beat(text[i], 1'b1, !tail_empty && i == text.size() - 1);
		end
		if (tail_empty)
			send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	task automatic send_literal(input string s);
		text.delete();
		for (int i = 0; i < s.len(); i++)
			text.push_back(s[i]);
		send_text();
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin : stimulus
		int target;
		int max_digits;
		int r;
		int k;
		int n_int;
		int n_frac;
		bit paused;
		bit wide_sel;
		paused = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_literal("-12.50");
		send_literal("00");
		send_literal("-");
		text.delete();
		send_text();
		send_literal(".05");
		send_literal("1+.2.E3");
		text = '{8'h37, 8'hFF, 8'h00};
		send_text();

		for (int phase = 0; phase < 6; phase++) begin
			wide_sel = (phase % 2 == 1);
			drain_results();
			repeat (4) @(posedge clk);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= 3'(4 * int'(REG_WIDE_MODE));
			pwdata <= {31'd0, wide_sel};
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
			max_digits = wide_sel ? int'(WIDE_MAX_DIGITS) : int'(NARROW_MAX_DIGITS);

			if (phase == 2)
				hold_out = 1'b1;
			if (phase == 3)
				calm = 1'b1;
			target = chars_sent + PHASE_CHARS;
			while (chars_sent < target) begin
				if (phase == 3 && chars_sent >= target - PHASE_CHARS / 2)
					calm = 1'b0;
				if (phase == 4 && !paused && chars_sent >= target - PHASE_CHARS / 2) begin
					drain_results();
					paused = 1'b1;
				end
				r = $urandom_range(0, 99);
				text.delete();
				if (r < 70) begin
					// mostly well-formed number with random content, at times with too many digits or an exponent
					k = $urandom_range(0, 2);
					if (k == 1)
						text.push_back(CH_MINUS);
					else if (k == 2)
						text.push_back(CH_PLUS);
					repeat ($urandom_range(0, 2)) text.push_back(CH_0);
					k = $urandom_range(0, 99);
					if (k < 80)
						n_int = $urandom_range(0, 6);
					else if (k < 92)
						n_int = $urandom_range(7, max_digits);
					else
						n_int = $urandom_range(max_digits - 1, max_digits + 2);
					repeat (n_int) text.push_back(CH_0 + 8'($urandom_range(0, 9)));
					if ($urandom_range(0, 3) != 0) begin
						text.push_back(CH_POINT);
						k = $urandom_range(0, 99);
						n_frac = (k < 85) ? $urandom_range(0, 6) : $urandom_range(0, max_digits + 3);
						repeat (n_frac) text.push_back(CH_0 + 8'($urandom_range(0, 9)));
					end
					if ($urandom_range(0, 9) == 0) begin
						text.push_back($urandom_range(0, 1) ? CH_EXP_LOW : CH_EXP_UP);
						repeat ($urandom_range(1, 2)) text.push_back(CH_0 + 8'($urandom_range(0, 9)));
					end
				end else if (r < 92) begin
					// broken text: stray bytes, signs and points anywhere
					repeat ($urandom_range(1, 8)) begin
						k = $urandom_range(0, 7);
						case (k)
							0, 1: text.push_back(8'($urandom_range(0, 255)));
							2: text.push_back(CH_POINT);
							3: text.push_back(CH_MINUS);
							4: text.push_back(CH_PLUS);
							5: text.push_back($urandom_range(0, 1) ? CH_EXP_LOW : CH_EXP_UP);
							default: text.push_back(CH_0 + 8'($urandom_range(0, 9)));
						endcase
					end
				end
				send_text();
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("decimal_text_to_fixed_parser_tb: PASS");
		else
			$display("decimal_text_to_fixed_parser_tb: FAIL");
		$finish;
	end

	initial begin : receiver
		int span;
		wait (arst_n);
		forever begin
			if (hold_out) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_out = 1'b0;
			end
			span = calm ? 0 : gap_len();
			if (span > 0) begin
				out_stall <= 1'b1;
				repeat (span) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("decimal_text_to_fixed_parser_tb: FAIL");
		$finish;
	end

endmodule
